/* src/crcts_pkg.sv */
// ----------------------------------------------------------------------------
// crcts_pkg
// Shared codes, item types and the fixed CRC lookup table of the byte-stream
// CRC-32 block.
// ----------------------------------------------------------------------------
package crcts_pkg;

   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_DATA   = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ACTIVE   = 2'd1;
   localparam logic [1:0] ST_INACTIVE = 2'd2;

   localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] ENTRY_XOR    = 32'h0000_00FF;

   localparam int REQ_DEPTH = 4;
   localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic [1:0]  req_type;
      logic        has_seed;
      logic [31:0] seed_value;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic        is_start;
      logic        is_data;
      logic        is_finish;
      logic        has_seed;
      logic [31:0] seed_value;
      logic [7:0]  data_byte;
   } cmd_type;

   typedef struct packed {
      logic [31:0] crc_value;
      logic [1:0]  status;
      logic        final_flag;
   } rsp_item_type;

   typedef logic [31:0] table_type [256];

   function automatic table_type build_table();
      table_type   t;
      logic [31:0] r;
      logic [7:0]  idx;
      for (int i = 0; i < 256; i++) begin
         idx = 8'(255 - i);
         r = {idx, 24'h0};
         for (int k = 0; k < 8; k++) begin
            if (r[31]) begin
               r = {r[30:0], 1'b0} ^ CRC_POLY;
            end else begin
               r = {r[30:0], 1'b0};
            end
         end
         t[i] = r ^ ENTRY_XOR;
      end
      return t;
   endfunction

   localparam table_type CRC_TABLE = build_table();

endpackage

/* src/crcts_front.sv */
// ----------------------------------------------------------------------------
// crcts_front
// Request queue: holds accepted items and presents the oldest one to the
// engine as a classified command.
// ----------------------------------------------------------------------------
module crcts_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  crcts_pkg::req_item_type req_item,
   output logic                  cmd_valid,
   output crcts_pkg::cmd_type    cmd,
   input  logic                  cmd_pop
);

   crcts_pkg::req_item_type              mem_ff [crcts_pkg::REQ_DEPTH];
   logic [crcts_pkg::REQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [crcts_pkg::REQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [crcts_pkg::REQ_PTR_W:0]        count_ff, count_in;
   logic                                 do_push;
   logic                                 do_pop;
   crcts_pkg::req_item_type              head;

   assign full      = (count_ff == (crcts_pkg::REQ_PTR_W+1)'(crcts_pkg::REQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      cmd.is_start   = (head.req_type == crcts_pkg::REQ_START);
      cmd.is_data    = (head.req_type == crcts_pkg::REQ_DATA);
      cmd.is_finish  = (head.req_type == crcts_pkg::REQ_FINISH);
      cmd.has_seed   = head.has_seed;
      cmd.seed_value = head.seed_value;
      cmd.data_byte  = head.data_byte;
   end

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

/* src/crcts_back.sv */
// ----------------------------------------------------------------------------
// crcts_back
// CRC engine: executes start, data and finish commands, pads a finish with
// zero bytes one per cycle unless rsp_full, and posts one result per command.
// ----------------------------------------------------------------------------
module crcts_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  crcts_pkg::cmd_type      cmd,
   output logic                    cmd_pop,
   input  logic                    rsp_full,
   output logic                    rsp_push,
   output crcts_pkg::rsp_item_type rsp_item
);

   logic [31:0] crc_ff, crc_in;
   logic [1:0]  count_ff, count_in;
   logic        active_ff, active_in;
   logic        pad_ff, pad_in;
   logic [7:0]  feed_byte;
   logic [7:0]  tbl_idx;
   logic [31:0] crc_fed;

   assign feed_byte = pad_ff ? 8'h00 : cmd.data_byte;
   assign tbl_idx   = crc_ff[31:24] ^ feed_byte;
   assign crc_fed   = {crc_ff[23:0], 8'h00} ^ crcts_pkg::CRC_TABLE[tbl_idx];
   assign cmd_pop   = cmd_valid && !pad_ff && !rsp_full;

   always_comb begin
      crc_in              = crc_ff;
      count_in            = count_ff;
      active_in           = active_ff;
      pad_in              = pad_ff;
      rsp_push            = 1'b0;
      rsp_item.status     = crcts_pkg::ST_OK;
      rsp_item.final_flag = 1'b0;
      if (pad_ff) begin
         if (!rsp_full) begin
            crc_in   = crc_fed;
            count_in = count_ff + 1'b1;
            if (count_ff == 2'd3) begin
               pad_in              = 1'b0;
               active_in           = 1'b0;
               rsp_push            = 1'b1;
               rsp_item.final_flag = 1'b1;
            end
         end
      end else if (cmd_pop) begin
         rsp_push = 1'b1;
         if (cmd.is_start) begin
            if (active_ff) begin
               rsp_item.status = crcts_pkg::ST_ACTIVE;
            end else begin
               crc_in    = cmd.has_seed ? cmd.seed_value : crcts_pkg::CRC_ALL_ONES;
               count_in  = 2'd0;
               active_in = 1'b1;
            end
         end else if (cmd.is_data) begin
            if (!active_ff) begin
               rsp_item.status = crcts_pkg::ST_INACTIVE;
            end else begin
               crc_in   = crc_fed;
               count_in = count_ff + 1'b1;
            end
         end else if (cmd.is_finish) begin
            if (!active_ff) begin
               rsp_item.status = crcts_pkg::ST_INACTIVE;
            end else if (count_ff == 2'd0) begin
               active_in           = 1'b0;
               rsp_item.final_flag = 1'b1;
            end else begin
               pad_in   = 1'b1;
               rsp_push = 1'b0;
            end
         end
      end
      rsp_item.crc_value = crc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= '0;
         count_ff  <= '0;
         active_ff <= 1'b0;
         pad_ff    <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         active_ff <= active_in;
         pad_ff    <= pad_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pad_active: assert property (@(posedge clock) disable iff (reset)
      pad_ff |-> active_ff)
      else $error("padding while idle");
   a_pad_count: assert property (@(posedge clock) disable iff (reset)
      pad_ff |-> (count_ff != 2'd0))
      else $error("padding with aligned byte count");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result posted into full queue");
   a_final_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_item.final_flag) |=> !active_ff)
      else $error("final result left run active");
`endif

endmodule

/* src/crcts_rspq.sv */
// ----------------------------------------------------------------------------
// crcts_rspq
// Result queue: holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module crcts_rspq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rsp_push,
   input  crcts_pkg::rsp_item_type rsp_item,
   output logic                    rsp_full,
   output logic                    empty,
   input  logic                    pop,
   output crcts_pkg::rsp_item_type head
);

   crcts_pkg::rsp_item_type         mem_ff [crcts_pkg::RSP_DEPTH];
   logic [crcts_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [crcts_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [crcts_pkg::RSP_PTR_W:0]   count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign rsp_full = (count_ff == (crcts_pkg::RSP_PTR_W+1)'(crcts_pkg::RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = rsp_push && !rsp_full;
   assign do_pop   = pop && !empty;
   assign head     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= rsp_item;
      end
   end

endmodule

/* src/crc32_msb_table_stream.sv */
// Flow: an accepted item is written into the request queue; the engine runs
//   it from the queue head and writes its result into the result queue, whose
//   head drives the result ports. A finish with an unaligned byte count first
//   feeds its zero pad bytes (<= 3). Throughput: one start or data item per
//   cycle unless the result queue is full or a finish is padding.
// Reset: synchronous; empties both queues, clears CRC, byte count and run.
// ----------------------------------------------------------------------------
// crc32_msb_table_stream
// Byte-stream CRC-32, MSB first, with a fixed 256-entry table, a request
// queue in front of the engine and a result queue behind it.
// ----------------------------------------------------------------------------
module crc32_msb_table_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic        req_has_seed,
   input  logic [31:0] req_seed_value,
   input  logic [7:0]  req_data_byte,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_crc_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_final_flag
);

   crcts_pkg::req_item_type req_item;
   crcts_pkg::cmd_type      cmd;
   crcts_pkg::rsp_item_type eng_item;
   crcts_pkg::rsp_item_type head;
   logic                    cmd_valid;
   logic                    cmd_pop;
   logic                    rsp_full;
   logic                    rsp_push;

   assign req_item.req_type   = req_type;
   assign req_item.has_seed   = req_has_seed;
   assign req_item.seed_value = req_seed_value;
   assign req_item.data_byte  = req_data_byte;

   crcts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   crcts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (eng_item)
   );

   crcts_rspq u_rspq (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_item (eng_item),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .head     (head)
   );

   assign rsp_crc_value  = head.crc_value;
   assign rsp_status     = head.status;
   assign rsp_final_flag = head.final_flag;

endmodule
